// ===== src/ryp_pkg.sv =====
package ryp_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned REG_W   = 13;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned COMP_W  = 8;
    localparam int unsigned ADDR_W  = 41;
    localparam int unsigned PLANE_W = 2;

    // Derived internal widths.
    localparam int unsigned AREA_W = 2 * REG_W;
    localparam int unsigned RW_W   = COORD_W + REG_W;
    localparam int unsigned FA_W   = FRAME_W + AREA_W;

    // Plane codes.
    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    // Register indexes (decoded from paddr[2]).
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    // One converted pixel as it leaves the pipeline.
    typedef struct packed {
        logic [ADDR_W-1:0] y_addr;
        logic [ADDR_W-1:0] u_addr;
        logic [ADDR_W-1:0] v_addr;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] u;
        logic [COMP_W-1:0] v;
        logic              chroma;
    } t_pix;

endpackage

// ===== src/ryp_color.sv =====
module ryp_color
    import ryp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [COMP_W-1:0] i_red,
    input  logic [COMP_W-1:0] i_green,
    input  logic [COMP_W-1:0] i_blue,
    output logic [COMP_W-1:0] o_y,
    output logic [COMP_W-1:0] o_u,
    output logic [COMP_W-1:0] o_v
);

    localparam int unsigned PROD_W = 24;
    localparam int unsigned SUM_W  = 27;
    localparam int unsigned FRAC   = 16;

    // Coefficient magnitudes with 16 fraction bits; signs are applied in the sums.
    localparam logic [15:0] K_YR = 16'd19595;
    localparam logic [15:0] K_YG = 16'd38470;
    localparam logic [15:0] K_YB = 16'd7471;
    localparam logic [15:0] K_UR = 16'd11076;
    localparam logic [15:0] K_UG = 16'd21692;
    localparam logic [15:0] K_UB = 16'd32768;
    localparam logic [15:0] K_VR = 16'd32768;
    localparam logic [15:0] K_VG = 16'd27460;
    localparam logic [15:0] K_VB = 16'd5308;
    localparam logic [SUM_W-1:0] OFFS = SUM_W'(128) << FRAC;

    function automatic logic [COMP_W-1:0] clamp_sample(input logic signed [SUM_W-1:0] s);
        logic [COMP_W-1:0] res;
        if (s[SUM_W-1]) begin
            res = '0;
        end else if (|s[SUM_W-2:FRAC+COMP_W]) begin
            res = '1;
        end else begin
            res = s[FRAC+COMP_W-1:FRAC];
        end
        return res;
    endfunction

    logic [PROD_W-1:0] r_yr, r_yg, r_yb, r_ur, r_ug, r_ub, r_vr, r_vg, r_vb;
    logic signed [SUM_W-1:0] r_ys, r_us, r_vs;
    logic [COMP_W-1:0] r_y3, r_u3, r_v3;
    logic [COMP_W-1:0] r_y4, r_u4, r_v4;

    // Stage 1: constant products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yr <= PROD_W'(K_YR) * PROD_W'(i_red);
            r_yg <= PROD_W'(K_YG) * PROD_W'(i_green);
            r_yb <= PROD_W'(K_YB) * PROD_W'(i_blue);
            r_ur <= PROD_W'(K_UR) * PROD_W'(i_red);
            r_ug <= PROD_W'(K_UG) * PROD_W'(i_green);
            r_ub <= PROD_W'(K_UB) * PROD_W'(i_blue);
            r_vr <= PROD_W'(K_VR) * PROD_W'(i_red);
            r_vg <= PROD_W'(K_VG) * PROD_W'(i_green);
            r_vb <= PROD_W'(K_VB) * PROD_W'(i_blue);
        end
    end

    // Stage 2: signed sums; stage 3: floor and clamp; stage 4: align with addresses.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ys <= $signed(SUM_W'(r_yr) + SUM_W'(r_yg) + SUM_W'(r_yb));
            r_us <= $signed(SUM_W'(r_ub) + OFFS - SUM_W'(r_ur) - SUM_W'(r_ug));
            r_vs <= $signed(SUM_W'(r_vr) + OFFS - SUM_W'(r_vg) - SUM_W'(r_vb));
            r_y3 <= clamp_sample(r_ys);
            r_u3 <= clamp_sample(r_us);
            r_v3 <= clamp_sample(r_vs);
            r_y4 <= r_y3;
            r_u4 <= r_u3;
            r_v4 <= r_v3;
        end
    end

    assign o_y = r_y4;
    assign o_u = r_u4;
    assign o_v = r_v4;

endmodule

// ===== src/ryp_addr.sv =====
module ryp_addr
    import ryp_pkg::*;
#(
    parameter int unsigned MAX_DIM = 4096
)
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_col,
    input  logic [REG_W-1:0]   i_width_reg,
    input  logic [REG_W-1:0]   i_height_reg,
    output logic [ADDR_W-1:0]  o_y_addr,
    output logic [ADDR_W-1:0]  o_u_addr,
    output logic [ADDR_W-1:0]  o_v_addr,
    output logic               o_chroma
);

    logic [REG_W-1:0] w, h;

    // Dimensions above the supported maximum are treated as the maximum.
    always_comb begin
        w = ({19'b0, i_width_reg} > 32'(MAX_DIM)) ? REG_W'(MAX_DIM) : i_width_reg;
        h = ({19'b0, i_height_reg} > 32'(MAX_DIM)) ? REG_W'(MAX_DIM) : i_height_reg;
    end

    logic [FRAME_W-1:0] r1_frame;
    logic [AREA_W-1:0]  r1_area;
    logic [RW_W-1:0]    r1_rw;
    logic [COORD_W-1:0] r1_col;
    logic [FA_W-1:0]    r2_fa;
    logic [AREA_W-1:0]  r2_area;
    logic [AREA_W:0]    r2_a5;
    logic [RW_W:0]      r2_yoff;
    logic [RW_W-1:0]    r2_coff;
    logic [ADDR_W-1:0]  r3_base;
    logic [RW_W:0]      r3_yoff;
    logic [AREA_W+1:0]  r3_uoff;
    logic [AREA_W+1:0]  r3_voff;
    logic [ADDR_W-1:0]  r4_y, r4_u, r4_v;
    logic [3:0]         r_chroma;
    logic [FA_W+1:0]    fa3;

    assign fa3 = (FA_W+2)'(r2_fa) + (FA_W+2)'({r2_fa, 1'b0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Stage 1: frame area and row offset.
            r1_frame <= i_frame;
            r1_area  <= AREA_W'(w) * AREA_W'(h);
            r1_rw    <= RW_W'(i_row) * RW_W'(w);
            r1_col   <= i_col;
            // Stage 2: frame times area, plane offsets.
            r2_fa    <= FA_W'(r1_frame) * FA_W'(r1_area);
            r2_area  <= r1_area;
            r2_a5    <= (AREA_W+1)'(r1_area) + (AREA_W+1)'(r1_area >> 2);
            r2_yoff  <= (RW_W+1)'(r1_rw) + (RW_W+1)'(r1_col);
            r2_coff  <= (r1_rw >> 2) + RW_W'(r1_col >> 1);
            // Stage 3: frame base is 3/2 of frame times area, floored.
            r3_base  <= fa3[ADDR_W:1];
            r3_yoff  <= r2_yoff;
            r3_uoff  <= (AREA_W+2)'(r2_area) + (AREA_W+2)'(r2_coff);
            r3_voff  <= (AREA_W+2)'(r2_a5) + (AREA_W+2)'(r2_coff);
            // Stage 4: final addresses, wrapping at the address width.
            r4_y     <= r3_base + ADDR_W'(r3_yoff);
            r4_u     <= r3_base + ADDR_W'(r3_uoff);
            r4_v     <= r3_base + ADDR_W'(r3_voff);
            r_chroma <= {r_chroma[2:0], ~i_row[0] & ~i_col[0]};
        end
    end

    assign o_y_addr = r4_y;
    assign o_u_addr = r4_u;
    assign o_v_addr = r4_v;
    assign o_chroma = r_chroma[3];

endmodule

// ===== src/ryp_out.sv =====
module ryp_out
    import ryp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_pix               i_pix,
    output logic               o_load,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [PLANE_W-1:0] o_plane,
    output logic [ADDR_W-1:0]  o_addr,
    output logic [COMP_W-1:0]  o_sample,
    output logic               o_last
);

    t_pix               r_pix;
    logic [PLANE_W-1:0] r_idx, n_idx;
    logic               r_valid, n_valid;
    logic               take, done;

    assign take   = r_valid && i_tready;
    assign o_last = (r_idx == PLANE_V) || ((r_idx == PLANE_Y) && !r_pix.chroma);
    assign done   = take && o_last;
    assign o_load = !r_valid || done;

    always_comb begin
        unique case (r_idx)
            PLANE_U: begin
                o_addr   = r_pix.u_addr;
                o_sample = r_pix.u;
            end
            PLANE_V: begin
                o_addr   = r_pix.v_addr;
                o_sample = r_pix.v;
            end
            default: begin
                o_addr   = r_pix.y_addr;
                o_sample = r_pix.y;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (o_load && i_valid) begin
            n_valid = 1'b1;
            n_idx   = PLANE_Y;
        end else if (done) begin
            n_valid = 1'b0;
        end else if (take) begin
            n_idx = r_idx + PLANE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= PLANE_Y;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && i_valid) begin
            r_pix <= i_pix;
        end
    end

    assign o_tvalid = r_valid;
    assign o_plane  = r_idx;

`ifndef SYNTH
    a_u_then_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (r_idx == PLANE_U) |=> r_valid && (r_idx == PLANE_V))
        else $error("chroma U write not followed by V write");
    a_no_chroma_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_pix.chroma |-> r_idx == PLANE_Y)
        else $error("chroma write for a pixel without chroma");
    a_u_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_idx == PLANE_U) |-> !o_last)
        else $error("U write marked last");
`endif

endmodule

// ===== src/rgb_to_yuv420_planar_writer.sv =====
// RGB to planar YUV 4:2:0 writer. Each input request carries one RGB pixel with
// its frame index and top-down row and column; the block answers with byte-write
// requests for a planar frame store: always a Y write, and for pixels on an even
// row and even column also a U write and then a V write, taken from that pixel
// alone. The target plane of each write travels on tuser, and the last write of
// each pixel has tlast set. Frame geometry comes from the frame_width and
// frame_height registers, which must only be changed while the block is idle.
// A pixel enters in every cycle in which the output register can take one; it
// flows through a four-stage conversion pipeline and then an output register
// that sends its writes one per cycle while tready is high, so the pipeline
// holds later pixels in its stages as earlier writes drain, and stalls while
// the output register holds writes of an earlier pixel. Pixels whose frame
// index is at or above MAX_FRAMES are accepted and produce no writes.
module rgb_to_yuv420_planar_writer
    import ryp_pkg::*;
#(
    parameter int unsigned MAX_DIM    = 4096,
    parameter int unsigned MAX_FRAMES = 65536
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input pixel stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: frame_index[15:0], row[11:0], col[11:0], red, green, blue.
    input  logic [63:0] s_axis_tdata,
    // Output write stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: byte_address[40:0], sample[7:0], seven zero bits.
    output logic [55:0] m_axis_tdata,
    // tuser from bit 0: plane[1:0].
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [REG_W-1:0] r_width_reg;
    logic [REG_W-1:0] r_height_reg;

    // Registers sit at byte addresses 0 and 4; only paddr[2] selects between them.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_HEIGHT) ? 32'(r_height_reg) : 32'(r_width_reg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_reg  <= REG_W'(640);
            r_height_reg <= REG_W'(480);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_IDX_HEIGHT) begin
                r_height_reg <= pwdata[REG_W-1:0];
            end else begin
                r_width_reg <= pwdata[REG_W-1:0];
            end
        end
    end

    // Unpack the input request.
    logic [FRAME_W-1:0] in_frame;
    logic [COORD_W-1:0] in_row, in_col;
    logic [COMP_W-1:0]  in_red, in_green, in_blue;

    assign in_frame = s_axis_tdata[15:0];
    assign in_row   = s_axis_tdata[27:16];
    assign in_col   = s_axis_tdata[39:28];
    assign in_red   = s_axis_tdata[47:40];
    assign in_green = s_axis_tdata[55:48];
    assign in_blue  = s_axis_tdata[63:56];

    // The whole pipeline advances together; it stops whenever the output
    // register still holds writes of an earlier pixel that do not finish in
    // this cycle.
    logic       en;
    logic [3:0] r_v;
    logic       in_keep;

    assign in_keep       = s_axis_tvalid && ({16'b0, in_frame} < 32'(MAX_FRAMES));
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], in_keep};
        end
    end

    t_pix               pix;
    logic [COMP_W-1:0]  col_y, col_u, col_v;
    logic [ADDR_W-1:0]  adr_y, adr_u, adr_v;
    logic               adr_chroma;

    ryp_color u_color (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_red   (in_red),
        .i_green (in_green),
        .i_blue  (in_blue),
        .o_y     (col_y),
        .o_u     (col_u),
        .o_v     (col_v)
    );

    ryp_addr #(
        .MAX_DIM (MAX_DIM)
    ) u_addr (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_frame      (in_frame),
        .i_row        (in_row),
        .i_col        (in_col),
        .i_width_reg  (r_width_reg),
        .i_height_reg (r_height_reg),
        .o_y_addr     (adr_y),
        .o_u_addr     (adr_u),
        .o_v_addr     (adr_v),
        .o_chroma     (adr_chroma)
    );

    // Both halves leave stage four together and form one pixel record.
    always_comb begin
        pix.y_addr = adr_y;
        pix.u_addr = adr_u;
        pix.v_addr = adr_v;
        pix.y      = col_y;
        pix.u      = col_u;
        pix.v      = col_v;
        pix.chroma = adr_chroma;
    end

    logic [PLANE_W-1:0] out_plane;
    logic [ADDR_W-1:0]  out_addr;
    logic [COMP_W-1:0]  out_sample;
    logic               out_load;

    // Stage four drains only when the output register can take it; an empty
    // output register also lets bubbles pass.
    assign en = out_load;

    ryp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v[3]),
        .i_pix    (pix),
        .o_load   (out_load),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_plane  (out_plane),
        .o_addr   (out_addr),
        .o_sample (out_sample),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, out_sample, out_addr};
    assign m_axis_tuser = out_plane;

endmodule

// ===== bench/ryp_checker.sv =====
module ryp_checker
    import ryp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_writes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned DIM_LIMIT = 4096;

    typedef struct {
        logic [PLANE_W-1:0] plane;
        logic [ADDR_W-1:0]  addr;
        logic [COMP_W-1:0]  sample;
        logic               last;
    } t_store_write;

    t_store_write     expected_writes[$];
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;
    int               mismatches = 0;
    int               writes_seen = 0;

    assign o_errors = mismatches;
    assign o_writes = writes_seen;

    // Fixed-point color matrix row: floor of the sum, then clamped to a byte.
    function automatic logic [COMP_W-1:0] color_sample(int kr, int kg, int kb, int offset,
                                                       int r, int g, int b);
        longint acc;
        acc = longint'(kr) * r + longint'(kg) * g + longint'(kb) * b
              + longint'(offset) * 65536;
        if (acc < 0)
            return '0;
        acc = acc >>> 16;
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    task automatic predict_writes(logic [63:0] px);
        longint unsigned w, h, area, base, chroma_off, frame, row, col;
        int              r, g, b;
        logic            chroma;
        t_store_write    wr;
        frame  = px[15:0];
        row    = px[27:16];
        col    = px[39:28];
        r      = px[47:40];
        g      = px[55:48];
        b      = px[63:56];
        w      = (width_reg > DIM_LIMIT) ? DIM_LIMIT : width_reg;
        h      = (height_reg > DIM_LIMIT) ? DIM_LIMIT : height_reg;
        area   = w * h;
        base   = (frame * area * 3) / 2;
        chroma = !px[16] && !px[28];

        wr.plane  = PLANE_Y;
        wr.addr   = ADDR_W'(base + row * w + col);
        wr.sample = color_sample(19595, 38470, 7471, 0, r, g, b);
        wr.last   = !chroma;
        expected_writes = {expected_writes, wr};
        if (chroma) begin
            chroma_off = (row * w) / 4 + col / 2;
            wr.plane  = PLANE_U;
            wr.addr   = ADDR_W'(base + area + chroma_off);
            wr.sample = color_sample(-11076, -21692, 32768, 128, r, g, b);
            wr.last   = 1'b0;
            expected_writes = {expected_writes, wr};
            wr.plane  = PLANE_V;
            wr.addr   = ADDR_W'(base + (area * 5) / 4 + chroma_off);
            wr.sample = color_sample(32768, -27460, -5308, 128, r, g, b);
            wr.last   = 1'b1;
            expected_writes = {expected_writes, wr};
        end
    endtask

    task automatic field_check(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, name,
                         want, got);
        end
    endtask

    task automatic check_write(logic [55:0] data, logic [1:0] user, logic tlast);
        t_store_write want;
        if (expected_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected write: plane %0d addr 0x%0h sample 0x%0h",
                         $realtime, user, data[40:0], data[48:41]);
        end else begin
            want = expected_writes.pop_front();
            field_check("plane", want.plane, user);
            field_check("byte_address", want.addr, data[40:0]);
            field_check("sample", want.sample, data[48:41]);
            field_check("tlast", want.last, tlast);
            field_check("tdata padding", 0, data[55:49]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  <= REG_W'(640);
            height_reg <= REG_W'(480);
            expected_writes.delete();
            o_pending  <= 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_IDX_WIDTH)
                        width_reg <= i_pwdata[REG_W-1:0];
                    else
                        height_reg <= i_pwdata[REG_W-1:0];
                end else begin
                    field_check(i_paddr[2] == REG_IDX_WIDTH ? "frame_width read" :
                                "frame_height read",
                                i_paddr[2] == REG_IDX_WIDTH ? width_reg : height_reg,
                                i_prdata);
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_writes(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                writes_seen++;
                check_write(i_m_tdata, i_m_tuser, i_m_tlast);
            end
            o_pending <= expected_writes.size();
        end
    end

endmodule

// ===== bench/tb_rgb_to_yuv420_planar_writer.sv =====
module tb_rgb_to_yuv420_planar_writer;
    import ryp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 5;
    localparam int STALL_MAX    = 8;
    // The drain pause covers the pipeline's path to its first write with a wide
    // margin so no pixel is still in flight at a register write.
    localparam int DRAIN_CYCLES = 20;
    // The slowest correct run is about 110 pixels, each with the longest input gap
    // and three writes that each wait out the longest stall, plus drains and
    // register traffic; the limit is far above that.
    localparam int CYCLE_LIMIT  = 300_000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 11;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int writes_checked;
    int cycles        = 0;
    int pixels_sent   = 0;
    int reg_reads     = 0;

    // When set, the sender or the receiver runs without any idle cycles.
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    // Frame geometries visited in turn: the smallest legal frame, the largest,
    // values above the 4096 ceiling, the degenerate zero and one sizes, odd
    // sizes where the quarter-plane offsets round down, and a common size.
    int unsigned geom_w[PHASES] = '{2, 4096, 8191, 0, 1, 4097, 7, 640};
    int unsigned geom_h[PHASES] = '{2, 4096, 8190, 0, 1, 3, 5, 480};

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    rgb_to_yuv420_planar_writer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    ryp_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .i_m_tlast  (m_axis_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_prdata   (prdata),
        .i_pready   (pready),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_writes   (writes_checked)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d writes outstanding", cycles, pending);
            $display("** rgb_to_yuv420_planar_writer: FAILED **");
            $finish;
        end
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, STALL_MAX));
    endfunction

    // Input tdata layout from bit 0: frame_index, row, col, red, green, blue.
    function automatic logic [63:0] pack_pixel(logic [15:0] frame, logic [11:0] row,
                                               logic [11:0] col, logic [7:0] r,
                                               logic [7:0] g, logic [7:0] b);
        return {b, g, r, col, row, frame};
    endfunction

    // Half of the pixels land inside the current frame of one of the first four
    // frame slots, so the addresses follow a real raster; a quarter carry a
    // full-range frame index, and a quarter are plain noise over every field.
    function automatic logic [63:0] random_pixel(int unsigned w, int unsigned h);
        int unsigned wd, hd, mode;
        logic [15:0] frame;
        logic [11:0] row, col;
        wd   = (w > 4096) ? 4096 : ((w == 0) ? 1 : w);
        hd   = (h > 4096) ? 4096 : ((h == 0) ? 1 : h);
        mode = $urandom_range(0, 3);
        if (mode == 3) begin
            frame = 16'($urandom);
            row   = 12'($urandom);
            col   = 12'($urandom);
        end else begin
            frame = (mode == 2) ? 16'($urandom) : 16'($urandom_range(0, 3));
            row   = 12'($urandom_range(0, hd - 1));
            col   = 12'($urandom_range(0, wd - 1));
        end
        return pack_pixel(frame, row, col, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Offers one pixel request after a random gap and returns at the clock edge
    // that accepts it. The valid line is left high so a back-to-back pixel can
    // follow without a bubble; hold_input drops it when the stream pauses.
    task automatic send_pixel(logic [63:0] px);
        int gap;
        gap = draw_wait(tx_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        pixels_sent++;
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Waits until every predicted write has come out, then lets the pipeline
    // settle so nothing is in flight when the registers change.
    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Register write: a setup cycle, then an access cycle with penable high.
    task automatic reg_write(logic idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Register read; the checker compares prdata during the access cycle.
    task automatic reg_read(logic idx);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_reads++;
    endtask

    // The receiver draws a stall before each write request, then holds tready
    // high until that write has been taken.
    initial begin
        int stall;
        @(negedge i_clk);
        forever begin
            stall = draw_wait(rx_calm);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry must read back as 640 by 480.
        reg_read(REG_IDX_WIDTH);
        reg_read(REG_IDX_HEIGHT);

        // Directed pixels at the reset geometry: the four row and column
        // parities, two frame corners, black and white, the primaries and
        // their complements (these push U and V to their clamps), pixels
        // outside the frame, and alternating bit patterns on every field.
        send_pixel(pack_pixel(16'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0));
        send_pixel(pack_pixel(16'd0, 12'd0, 12'd0, 8'd255, 8'd255, 8'd255));
        send_pixel(pack_pixel(16'd0, 12'd0, 12'd1, 8'd255, 8'd0, 8'd0));
        send_pixel(pack_pixel(16'd0, 12'd1, 12'd0, 8'd0, 8'd255, 8'd0));
        send_pixel(pack_pixel(16'd0, 12'd1, 12'd1, 8'd0, 8'd0, 8'd255));
        send_pixel(pack_pixel(16'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd255));
        send_pixel(pack_pixel(16'd0, 12'd0, 12'd2, 8'd255, 8'd0, 8'd0));
        send_pixel(pack_pixel(16'd0, 12'd2, 12'd0, 8'd0, 8'd255, 8'd0));
        send_pixel(pack_pixel(16'd0, 12'd2, 12'd2, 8'd255, 8'd255, 8'd0));
        send_pixel(pack_pixel(16'd0, 12'd2, 12'd4, 8'd0, 8'd255, 8'd255));
        send_pixel(pack_pixel(16'd0, 12'd4, 12'd6, 8'd255, 8'd0, 8'd255));
        send_pixel(pack_pixel(16'd0, 12'd479, 12'd639, 8'd128, 8'd128, 8'd128));
        send_pixel(pack_pixel(16'd0, 12'd478, 12'd638, 8'd1, 8'd254, 8'd127));
        send_pixel(pack_pixel(16'd1, 12'd480, 12'd0, 8'd200, 8'd10, 8'd90));
        send_pixel(pack_pixel(16'd2, 12'd0, 12'd640, 8'd10, 8'd200, 8'd30));
        send_pixel(pack_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 8'd255, 8'd255, 8'd255));
        send_pixel(pack_pixel(16'hFFFF, 12'hFFE, 12'hFFE, 8'd0, 8'd0, 8'd255));
        send_pixel(pack_pixel(16'hAAAA, 12'hAAA, 12'h554, 8'hAA, 8'h55, 8'hAA));
        send_pixel(pack_pixel(16'h5555, 12'h554, 12'hAAA, 8'h55, 8'hAA, 8'h55));
        send_pixel(pack_pixel(16'h7FFF, 12'h800, 12'h7FE, 8'h80, 8'h7F, 8'h01));
        hold_input();

        for (int p = 0; p < PHASES; p++) begin
            // Registers change only with the block idle.
            wait_drained();
            reg_write(REG_IDX_WIDTH, geom_w[p]);
            reg_write(REG_IDX_HEIGHT, geom_h[p]);
            reg_read(REG_IDX_WIDTH);
            reg_read(REG_IDX_HEIGHT);

            // Rotate through free-running and throttled sides so gaps land on
            // every pipeline phase and some stretches run at full rate.
            tx_calm = (p % 4 == 1) || (p % 4 == 3);
            rx_calm = (p % 4 == 2) || (p % 4 == 3);

            // Each geometry opens with the highest frame slot and row and column 4094,
            // which give large addresses in this geometry.
            send_pixel(pack_pixel(16'hFFFF, 12'd4094, 12'd4094, 8'($urandom), 8'($urandom),
                                  8'($urandom)));
            for (int k = 1; k < PHASE_ITEMS; k++) begin
                // Once mid-phase, stop sending until every write has come out.
                if (p == 2 && k == PHASE_ITEMS / 2) begin
                    hold_input();
                    wait_drained();
                end
                send_pixel(random_pixel(geom_w[p], geom_h[p]));
            end
            hold_input();
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        wait_drained();

        $display("Run covered %0d pixels over %0d frame geometries plus the reset one,",
                 pixels_sent, PHASES);
        $display("with %0d store writes checked and %0d register reads compared.",
                 writes_checked, reg_reads);
        if (errors == 0) begin
            $display("** rgb_to_yuv420_planar_writer: PASSED **");
        end else begin
            $display("%0d mismatches found", errors);
            $display("** rgb_to_yuv420_planar_writer: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/ryp_pkg.sv
src/ryp_color.sv
src/ryp_addr.sv
src/ryp_out.sv
src/rgb_to_yuv420_planar_writer.sv
bench/ryp_checker.sv
bench/tb_rgb_to_yuv420_planar_writer.sv
